// ===== src/acu_pkg.sv =====
// ----------------------------------------------------------------------------
// acu_pkg
// Shared types and constants of the accumulator machine execute unit:
// field widths, fixed register indices, item kinds and opcode encodings.
// ----------------------------------------------------------------------------
package acu_pkg;

    localparam int DATA_W    = 8;
    localparam int INSTR_W   = 9;
    localparam int REG_COUNT = 16;
    localparam int REG_AW    = 4;
    localparam int KIND_W    = 2;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 32;

    localparam logic [REG_AW-1:0] IDX_ACC  = 4'd0;
    localparam logic [REG_AW-1:0] IDX_FLAG = 4'd14;
    localparam logic [REG_AW-1:0] IDX_PC   = 4'd15;

    typedef enum logic [KIND_W-1:0] {
        KIND_EXEC  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        ROP_ADD  = 4'd0,
        ROP_SUB  = 4'd1,
        ROP_OR   = 4'd2,
        ROP_AND  = 4'd3,
        ROP_MVF  = 4'd4,
        ROP_MVT  = 4'd5,
        ROP_XOR  = 4'd6,
        ROP_PRT  = 4'd7,
        ROP_LDR  = 4'd8,
        ROP_STR  = 4'd9,
        ROP_CEQ  = 4'd10,
        ROP_CLT  = 4'd11,
        ROP_NORR = 4'd12,
        ROP_B    = 4'd13,
        ROP_BT   = 4'd14,
        ROP_LSL  = 4'd15
    } t_reg_op;

    // immediate ops carry a one in the top opcode bit, so only the low three vary
    typedef enum logic [2:0] {
        IOP_ADDI = 3'd0,
        IOP_SUBI = 3'd1,
        IOP_ORI  = 3'd2,
        IOP_ANDI = 3'd3,
        IOP_LSLI = 3'd4,
        IOP_LSRI = 3'd5,
        IOP_MVI  = 3'd6,
        IOP_XORI = 3'd7
    } t_imm_op;

endpackage

// ===== src/acu_ram.sv =====
// ----------------------------------------------------------------------------
// acu_ram
// Generic single-clock RAM: one write port, one read port with registered
// read data (read-first on address collision).
// ----------------------------------------------------------------------------
module acu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ===== src/accumulator_cpu_execute_unit_top.sv =====
// ----------------------------------------------------------------------------
// accumulator_cpu_execute_unit_top
// Execute unit of an 8-bit accumulator machine with register file and
// byte-wide data memory held in synchronous RAMs.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per item: tuser is the kind (execute, write
//   data memory, read data memory, none), tdata the instruction word, the
//   data memory address and the write byte. m_axis returns one result per
//   request: next pc, accumulator, flag register and the read byte.
//   Pipeline: accept cycle reads the register RAM at rn, the execute stage
//   computes and writes back, a result register drives m_axis. Memory
//   loads (LDR and kind read) pass through a load stage between the
//   execute stage and the result register.
//   Throughput: one request per cycle while m_axis does not stall, except
//   that a load holds the next request in the execute stage until the load
//   stage has pushed its result, since the loaded byte can feed that next
//   request.
//   A register RAM write that collides with the next request's read is
//   forwarded.
//   Reset clears r0, r14, r15 and the valid bits of both RAMs, so every
//   entry reads zero until written; no clearing pass is needed.
//   When m_axis stalls, the result register holds and the pipeline backs up
//   into s_axis tready.
// ----------------------------------------------------------------------------
module accumulator_cpu_execute_unit_top #(
    parameter int DATA_DEPTH = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // instr [8:0], mem_addr [16:9], mem_data [24:17], zero [31:25]
    input  logic [acu_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    // kind [1:0]
    input  logic [acu_pkg::KIND_W-1:0]     i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // next_pc [7:0], acc [15:8], flag [23:16], read_data [31:24]
    output logic [acu_pkg::M_TDATA_W-1:0]  o_m_axis_tdata
);

    import acu_pkg::*;

    localparam int AW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;

    // input fields
    logic [INSTR_W-1:0] w_in_instr;
    logic [DATA_W-1:0]  w_in_addr;
    logic [DATA_W-1:0]  w_in_data;
    logic [REG_AW-1:0]  w_in_rn;
    logic               w_accept;

    // architectural registers kept in flops
    logic [DATA_W-1:0]  r_acc;
    logic [DATA_W-1:0]  r_flag;
    logic [DATA_W-1:0]  r_pc;
    logic [REG_COUNT-1:0]  r_rvalid;
    logic [DATA_DEPTH-1:0] r_dvalid;

    // execute stage
    logic               r_s1_vld;
    t_kind              r_s1_kind;
    logic [INSTR_W-1:0] r_s1_instr;
    logic [DATA_W-1:0]  r_s1_addr;
    logic [DATA_W-1:0]  r_s1_data;
    logic               r_fw_hit;
    logic [DATA_W-1:0]  r_fw_data;

    // load stage
    logic               r_ld_vld;
    logic               r_ld_to_acc;
    logic               r_ld_dv;

    // result register
    logic               r_out_vld;
    logic [DATA_W-1:0]  r_out_pc;
    logic [DATA_W-1:0]  r_out_acc;
    logic [DATA_W-1:0]  r_out_flag;
    logic [DATA_W-1:0]  r_out_rd;

    logic [REG_AW-1:0]  w_rn;
    logic [DATA_W-1:0]  w_reg_rdata;
    logic [DATA_W-1:0]  w_v;
    logic [DATA_W-1:0]  n_acc;
    logic [DATA_W-1:0]  n_flag;
    logic [DATA_W-1:0]  n_pc;
    logic               w_is_load;
    logic               w_dm_wr;
    logic               w_reg_wr;
    logic [DATA_W-1:0]  w_dm_wdata;
    logic [DATA_W-1:0]  w_dm_src;
    logic [AW-1:0]      w_dm_addr;
    logic [DATA_W-1:0]  w_dm_rdata;
    logic [DATA_W-1:0]  w_ld_byte;
    logic [AW-1:0]      w_mod_tbl [256];

    logic               w_out_free;
    logic               w_s1_fire;
    logic               w_s1_push;
    logic               w_ld_push;
    logic               w_reg_we;
    logic               w_dm_we;
    logic               w_dm_re;

    assign w_in_instr = i_s_axis_tdata[8:0];
    assign w_in_addr  = i_s_axis_tdata[16:9];
    assign w_in_data  = i_s_axis_tdata[24:17];
    assign w_in_rn    = w_in_instr[REG_AW-1:0];
    assign w_rn       = r_s1_instr[REG_AW-1:0];

    // address wrap to the memory depth, one entry per byte value
    for (genvar g = 0; g < 256; g++) begin : g_mod
        assign w_mod_tbl[g] = AW'(g % DATA_DEPTH);
    end

    // handshake and stage control
    assign w_out_free      = !r_out_vld || i_m_axis_tready;
    assign w_s1_fire       = r_s1_vld && !r_ld_vld && (w_is_load || w_out_free);
    assign w_s1_push       = w_s1_fire && !w_is_load;
    assign w_ld_push       = r_ld_vld && w_out_free;
    assign o_s_axis_tready = !r_s1_vld || w_s1_fire;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_reg_we        = w_s1_fire && w_reg_wr;
    assign w_dm_we         = w_s1_fire && w_dm_wr;
    assign w_dm_re         = w_s1_fire && w_is_load;

    acu_ram #(
        .WIDTH (DATA_W),
        .DEPTH (REG_COUNT)
    ) u_reg_ram (
        .i_clk   (i_clk),
        .i_we    (w_reg_we),
        .i_waddr (w_rn),
        .i_wdata (r_acc),
        .i_re    (w_accept),
        .i_raddr (w_in_rn),
        .o_rdata (w_reg_rdata)
    );

    acu_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DATA_DEPTH)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (w_dm_we),
        .i_waddr (w_dm_addr),
        .i_wdata (w_dm_wdata),
        .i_re    (w_dm_re),
        .i_raddr (w_dm_addr),
        .o_rdata (w_dm_rdata)
    );

    // operand rn: fixed registers from flops, others from the RAM (forwarded on a collision, zero until written)
    always_comb begin
        case (w_rn)
            IDX_ACC:  w_v = r_acc;
            IDX_FLAG: w_v = r_flag;
            IDX_PC:   w_v = r_pc;
            default: begin
                if (r_fw_hit) begin
                    w_v = r_fw_data;
                end else if (r_rvalid[w_rn]) begin
                    w_v = w_reg_rdata;
                end else begin
                    w_v = '0;
                end
            end
        endcase
    end

    assign w_dm_src  = (r_s1_kind == KIND_EXEC) ? w_v : r_s1_addr;
    assign w_dm_addr = w_mod_tbl[w_dm_src];
    assign w_ld_byte = r_ld_dv ? w_dm_rdata : '0;

    // execute
    always_comb begin
        logic [DATA_W-1:0] uimm;
        logic [DATA_W-1:0] simm;
        logic [DATA_W-1:0] diff;
        uimm       = {3'b000, r_s1_instr[4:0]};
        simm       = {{3{r_s1_instr[4]}}, r_s1_instr[4:0]};
        diff       = r_acc - w_v;
        n_acc      = r_acc;
        n_flag     = r_flag;
        n_pc       = r_pc + 8'd1;
        w_is_load  = 1'b0;
        w_dm_wr    = 1'b0;
        w_reg_wr   = 1'b0;
        w_dm_wdata = r_acc;
        case (r_s1_kind)
            KIND_EXEC: begin
                if (!r_s1_instr[8]) begin
                    case (t_reg_op'(r_s1_instr[7:4]))
                        ROP_ADD:  n_acc = r_acc + w_v;
                        ROP_SUB:  n_acc = diff;
                        ROP_OR:   n_acc = r_acc | w_v;
                        ROP_AND:  n_acc = r_acc & w_v;
                        ROP_MVF:  n_acc = w_v;
                        ROP_MVT: begin
                            case (w_rn)
                                IDX_ACC:  n_acc = r_acc;
                                IDX_FLAG: n_flag = r_acc;
                                IDX_PC:   n_pc = r_acc + 8'd1;
                                default:  w_reg_wr = 1'b1;
                            endcase
                        end
                        ROP_XOR:  n_acc = r_acc ^ w_v;
                        ROP_PRT:  n_acc = {7'd0, ^w_v};
                        ROP_LDR:  w_is_load = 1'b1;
                        ROP_STR:  w_dm_wr = 1'b1;
                        ROP_CEQ:  n_flag = {7'd0, r_acc == w_v};
                        ROP_CLT:  n_flag = {7'd0, diff[7]};
                        ROP_NORR: n_acc = {7'd0, w_v == 8'd0};
                        ROP_B:    n_pc = r_pc + w_v;
                        ROP_BT: begin
                            if (r_flag[0]) begin
                                n_pc = r_pc + w_v;
                            end
                        end
                        ROP_LSL:  n_acc = (|w_v[7:3]) ? 8'd0 : (r_acc << w_v[2:0]);
                        default:  n_acc = r_acc;
                    endcase
                end else begin
                    case (t_imm_op'(r_s1_instr[7:5]))
                        IOP_ADDI: n_acc = r_acc + uimm;
                        IOP_SUBI: n_acc = r_acc - uimm;
                        IOP_ORI:  n_acc = r_acc | uimm;
                        IOP_ANDI: n_acc = r_acc & uimm;
                        IOP_LSLI: n_acc = (|uimm[4:3]) ? 8'd0 : (r_acc << uimm[2:0]);
                        IOP_LSRI: n_acc = (|uimm[4:3]) ? 8'd0 : (r_acc >> uimm[2:0]);
                        IOP_MVI:  n_acc = simm;
                        IOP_XORI: n_acc = r_acc ^ simm;
                        default:  n_acc = r_acc;
                    endcase
                end
            end
            KIND_WRITE: begin
                n_pc       = r_pc;
                w_dm_wr    = 1'b1;
                w_dm_wdata = r_s1_data;
            end
            KIND_READ: begin
                n_pc      = r_pc;
                w_is_load = 1'b1;
            end
            default: n_pc = r_pc;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_ld_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_acc     <= '0;
            r_flag    <= '0;
            r_pc      <= '0;
            r_rvalid  <= '0;
            r_dvalid  <= '0;
        end else begin
            if (w_accept) begin
                r_s1_vld <= 1'b1;
            end else if (w_s1_fire) begin
                r_s1_vld <= 1'b0;
            end
            if (w_dm_re) begin
                r_ld_vld <= 1'b1;
            end else if (w_ld_push) begin
                r_ld_vld <= 1'b0;
            end
            if (w_s1_push || w_ld_push) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            if (w_s1_fire) begin
                r_acc  <= n_acc;
                r_flag <= n_flag;
                r_pc   <= n_pc;
            end
            if (w_ld_push && r_ld_to_acc) begin
                r_acc <= w_ld_byte;
            end
            if (w_reg_we) begin
                r_rvalid[w_rn] <= 1'b1;
            end
            if (w_dm_we) begin
                r_dvalid[w_dm_addr] <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_kind  <= t_kind'(i_s_axis_tuser);
            r_s1_instr <= w_in_instr;
            r_s1_addr  <= w_in_addr;
            r_s1_data  <= w_in_data;
            // register ram read collides with a write in the same cycle
            r_fw_hit   <= w_reg_we && (w_rn == w_in_rn);
            r_fw_data  <= r_acc;
        end
        if (w_dm_re) begin
            r_ld_to_acc <= (r_s1_kind == KIND_EXEC);
            r_ld_dv     <= r_dvalid[w_dm_addr];
        end
        if (w_s1_push) begin
            r_out_pc   <= n_pc;
            r_out_acc  <= n_acc;
            r_out_flag <= n_flag;
            r_out_rd   <= '0;
        end else if (w_ld_push) begin
            r_out_pc   <= r_pc;
            r_out_acc  <= r_ld_to_acc ? w_ld_byte : r_acc;
            r_out_flag <= r_flag;
            r_out_rd   <= r_ld_to_acc ? 8'd0 : w_ld_byte;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {r_out_rd, r_out_flag, r_out_acc, r_out_pc};

    // a waiting load keeps its slot until the result register frees up
    a_ld_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ld_vld && !w_out_free |=> r_ld_vld)
        else $error("load stage dropped before its result was pushed");

    a_ld_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ld_push |=> r_out_vld && !r_ld_vld)
        else $error("load completion did not produce a result");

    a_reg_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_reg_we |-> (w_rn != IDX_ACC) && (w_rn != IDX_FLAG) && (w_rn != IDX_PC))
        else $error("register ram written at a flop-held register index");

    a_dm_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_dm_we && w_dm_re) && !(r_ld_vld && w_s1_fire))
        else $error("data memory access overlaps a pending load");

endmodule
